// ===== hdl/mbe_pkg.sv =====
// Shared types, constants and helpers for the Mandelbrot escape-time block.
// Used by mbe_mul, mbe_core and mandelbrot_escape_time; depends on nothing.
package mbe_pkg;

	// Fixed-point format: signed Q4.28
	localparam int FRAC_BITS = 28;
	localparam int PIX_W     = 10;
	localparam int COUNT_W   = 16;
	localparam int OP_W      = 33;
	localparam int PROD_W    = 2 * OP_W;
	localparam int SAT_W     = 48;
	localparam int SQ_W      = 36;
	localparam int XY_W      = 38;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_RE_ORIGIN = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_RE_STEP   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_IM_ORIGIN = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_IM_STEP   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITER  = 3'd4;

	// Register reset values
	localparam logic signed [31:0] RST_RE_ORIGIN = -32'sd536870912;
	localparam logic signed [31:0] RST_RE_STEP   = 32'sd786432;
	localparam logic signed [31:0] RST_IM_ORIGIN = 32'sd268435456;
	localparam logic signed [31:0] RST_IM_STEP   = -32'sd786432;
	localparam logic [COUNT_W-1:0] RST_MAX_ITER  = 16'd100;

	// Escape threshold 4.0 in Q4.28, at the width of the sum of two squares
	localparam logic signed [SQ_W:0] ESC_LIMIT = 37'sd1073741824;

	localparam logic signed [SAT_W-1:0] SAT_HI = 48'sd2147483647;
	localparam logic signed [SAT_W-1:0] SAT_LO = -48'sd2147483648;

	typedef struct packed {
		logic signed [31:0] re_origin;
		logic signed [31:0] re_step;
		logic signed [31:0] im_origin;
		logic signed [31:0] im_step;
		logic [COUNT_W-1:0] max_iter;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]   out_x;
		logic [PIX_W-1:0]   out_y;
		logic [COUNT_W-1:0] count;
		logic               escaped;
	} res_t;

	// Clamp a wide signed value to the 32-bit signed range
	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

endpackage

// ===== hdl/mbe_mul.sv =====
// Shared signed 33x33 multiplier with a registered product.
// Depends on mbe_pkg for operand and product widths.
module mbe_mul
	import mbe_pkg::*;
(
	input  logic                     clk,
	input  logic signed [OP_W-1:0]   a,
	input  logic signed [OP_W-1:0]   b,
	output logic signed [PROD_W-1:0] p
);

	logic signed [PROD_W-1:0] p_q;

	// Register the product; it is read in the cycle after the operands are issued
	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

// ===== hdl/mbe_core.sv =====
// Pixel mapping and escape-time iteration around one shared multiplier.
// Depends on mbe_pkg and instantiates mbe_mul.
module mbe_core
	import mbe_pkg::*;
#(
	parameter int COORD_MAX = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             start,
	input  logic [PIX_W-1:0] pixel_x,
	input  logic [PIX_W-1:0] pixel_y,
	output logic             ready,
	output logic             done,
	input  logic             take,
	output res_t             res
);

	localparam int IDX_W = (COORD_MAX > 2) ? $clog2(COORD_MAX) : 1;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_MAP_RE  = 9'b000000010,
		ST_MAP_IM  = 9'b000000100,
		ST_MAP_END = 9'b000001000,
		ST_SQ_X    = 9'b000010000,
		ST_SQ_Y    = 9'b000100000,
		ST_MUL_XY  = 9'b001000000,
		ST_TEST    = 9'b010000000,
		ST_DONE    = 9'b100000000
	} state_t;

	state_t state_q;

	logic [PIX_W-1:0]         px_q, py_q;
	logic [IDX_W-1:0]         idx_x_q, idx_y_q;
	logic signed [31:0]       c_re_q, c_im_q;
	logic signed [31:0]       x_q, y_q;
	logic signed [SQ_W-1:0]   xsq_q, ysq_q;
	logic [COUNT_W-1:0]       count_q;

	logic signed [OP_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [SQ_W:0]     mag;
	logic signed [XY_W-1:0]   xy_sh;
	logic signed [31:0]       map_val;
	logic signed [31:0]       next_x, next_y;
	logic                     stop;

	mbe_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// Select multiplier operands for the current step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MAP_RE: begin
				mul_a = OP_W'(cfg.re_step);
				mul_b = OP_W'(idx_x_q);
			end
			ST_MAP_IM: begin
				mul_a = OP_W'(cfg.im_step);
				mul_b = OP_W'(idx_y_q);
			end
			ST_SQ_X: begin
				mul_a = OP_W'(x_q);
				mul_b = OP_W'(x_q);
			end
			ST_SQ_Y: begin
				mul_a = OP_W'(y_q);
				mul_b = OP_W'(y_q);
			end
			ST_MUL_XY: begin
				mul_a = OP_W'(x_q);
				mul_b = OP_W'(y_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Mapping add, escape test and update
	always_comb begin
		if (state_q == ST_MAP_IM) begin
			map_val = sat32(SAT_W'(prod) + SAT_W'(cfg.re_origin));
		end else begin
			map_val = sat32(SAT_W'(prod) + SAT_W'(cfg.im_origin));
		end
		mag    = (SQ_W + 1)'(xsq_q) + (SQ_W + 1)'(ysq_q);
		stop   = (mag > ESC_LIMIT) || (count_q >= cfg.max_iter);
		xy_sh  = XY_W'(prod >>> (FRAC_BITS - 1));
		next_x = sat32(SAT_W'(xsq_q) - SAT_W'(ysq_q) + SAT_W'(c_re_q));
		next_y = sat32(SAT_W'(xy_sh) + SAT_W'(c_im_q));
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:    if (start) state_q <= ST_MAP_RE;
				ST_MAP_RE:  state_q <= ST_MAP_IM;
				ST_MAP_IM:  state_q <= ST_MAP_END;
				ST_MAP_END: state_q <= ST_SQ_X;
				ST_SQ_X:    state_q <= ST_SQ_Y;
				ST_SQ_Y:    state_q <= ST_MUL_XY;
				ST_MUL_XY:  state_q <= ST_TEST;
				ST_TEST:    state_q <= stop ? ST_DONE : ST_SQ_X;
				ST_DONE:    if (take) state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q <= pixel_x;
				py_q <= pixel_y;
				// Clamp indexes past the image for the mapping only
				if (32'(pixel_x) >= COORD_MAX) begin
					idx_x_q <= IDX_W'(COORD_MAX - 1);
				end else begin
					idx_x_q <= IDX_W'(pixel_x);
				end
				if (32'(pixel_y) >= COORD_MAX) begin
					idx_y_q <= IDX_W'(COORD_MAX - 1);
				end else begin
					idx_y_q <= IDX_W'(pixel_y);
				end
			end
			ST_MAP_IM: begin
				c_re_q <= map_val;
			end
			ST_MAP_END: begin
				c_im_q  <= map_val;
				x_q     <= '0;
				y_q     <= '0;
				count_q <= '0;
			end
			ST_SQ_Y: begin
				xsq_q <= SQ_W'(prod >>> FRAC_BITS);
			end
			ST_MUL_XY: begin
				ysq_q <= SQ_W'(prod >>> FRAC_BITS);
			end
			ST_TEST: begin
				if (!stop) begin
					x_q     <= next_x;
					y_q     <= next_y;
					count_q <= count_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign ready       = (state_q == ST_IDLE);
	assign done        = (state_q == ST_DONE);
	assign res.out_x   = px_q;
	assign res.out_y   = py_q;
	assign res.count   = count_q;
	assign res.escaped = (count_q != cfg.max_iter);

endmodule

// ===== hdl/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time evaluator, one pixel per input word.
// Channels: s_axis takes a pixel (column, row); m_axis returns the pixel, the
// iteration count and, on tuser, whether the point escaped. A word moves on a
// rising edge where tvalid and tready are both high.
// Configuration: cfg_we/cfg_addr/cfg_wdata write origins and steps (Q4.28 signed)
// and the unsigned iteration limit; the user must write them only while the block
// is idle, as the block does not enforce it; unknown indexes are ignored.
// Schedule: one shared 33x33 multiplier does the mapping (2 products) and three
// products per iteration (x*x, y*y, x*y), followed by the escape test; the
// default iteration limit is 100. One pixel is in work at a time, so the next
// pixel is accepted only after the previous one has been handed to the output
// register.
// s_axis_tready is high while the sequencer is idle; a new pixel is taken
// even when a finished word still waits in the output register.
// A stalled receiver holds m_axis steady; a finished pixel then waits in the
// core until the output register frees up.
// Reset clears the sequencer and output valid and loads default registers.
// Depends on mbe_pkg, mbe_core and mbe_mul.
module mandelbrot_escape_time
	import mbe_pkg::*;
#(
	parameter int COORD_MAX = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [23:0]           s_axis_tdata,  // pixel_x[9:0], pixel_y[19:10], zero
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [39:0]           m_axis_tdata,  // out_x[9:0], out_y[19:10],
	                                             // iteration_count[35:20], zero
	output logic                  m_axis_tuser,  // escaped
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [31:0]           cfg_wdata
);

	cfg_t cfg_q;
	res_t core_res;
	res_t out_q;
	logic out_valid_q;
	logic core_ready, core_done, take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.re_origin <= RST_RE_ORIGIN;
			cfg_q.re_step   <= RST_RE_STEP;
			cfg_q.im_origin <= RST_IM_ORIGIN;
			cfg_q.im_step   <= RST_IM_STEP;
			cfg_q.max_iter  <= RST_MAX_ITER;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_RE_ORIGIN: cfg_q.re_origin <= cfg_wdata;
				REG_RE_STEP:   cfg_q.re_step   <= cfg_wdata;
				REG_IM_ORIGIN: cfg_q.im_origin <= cfg_wdata;
				REG_IM_STEP:   cfg_q.im_step   <= cfg_wdata;
				REG_MAX_ITER:  cfg_q.max_iter  <= cfg_wdata[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mbe_core #(
		.COORD_MAX (COORD_MAX)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.start   (s_axis_tvalid),
		.pixel_x (s_axis_tdata[PIX_W-1:0]),
		.pixel_y (s_axis_tdata[2*PIX_W-1:PIX_W]),
		.ready   (core_ready),
		.done    (core_done),
		.take    (take),
		.res     (core_res)
	);

	assign s_axis_tready = core_ready;

	// Move a finished word into the output register when it is free
	assign take = core_done && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= core_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_q.count, out_q.out_y, out_q.out_x};
	assign m_axis_tuser  = out_q.escaped;

endmodule
